[rtl/enms_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the edge non-maximum suppression block.
package enms_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int DEFAULT_MAG_BITS  = 16;

    // Front-to-back column queue depth
    localparam int QUEUE_DEPTH = 4;

    // Fixed field widths
    localparam int DIR_W       = 3;
    localparam int ROW_W       = 12;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 12;
    localparam int TUSER_IN_W  = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    // Register reset values
    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    // Quantized gradient direction codes
    typedef enum logic [DIR_W-1:0] {
        DIR_NONE    = 3'd0,
        DIR_HORIZ   = 3'd1,
        DIR_VERT    = 3'd2,
        DIR_DIAG_UR = 3'd3,
        DIR_DIAG_UL = 3'd4
    } dir_t;

    // Per-column control carried from front to back
    typedef struct packed {
        logic first_col;  // window refills with this column
        logic last_col;   // row ends with this column
        logic emit;       // not the top row: results are due
        logic flush_row;  // column of the flush row
    } ctl_t;

endpackage

[rtl/enms_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module enms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/enms_fifo.sv]
`timescale 1ns / 1ps
// Small register queue between the column front end and the window back end.
module enms_fifo #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               push_data,
    input  logic                           pop,
    output logic [WIDTH-1:0]               head_data,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = store_reg[rd_ptr_reg];
    assign empty     = (level_reg == '0);
    assign level     = level_reg;

endmodule

[rtl/enms_front.sv]
`timescale 1ns / 1ps
// Front end: frame counters, line stores and column assembly into the queue.
module enms_front #(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAG_BITS    = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [enms_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [enms_pkg::CFG_DATA_W-1:0]        cfg_data,
    // pixel input
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [MAG_BITS-1:0]                    in_mag,
    input  logic [enms_pkg::DIR_W-1:0]             in_dir,
    // column queue
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]       q_level,
    output logic                                   q_push,
    output logic [3*MAG_BITS+enms_pkg::DIR_W+$bits(enms_pkg::ctl_t)-1:0] q_data
);

    import enms_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [COL_W-1:0] WIDTH_LAST_RESET = (FRAME_WIDTH_RESET > MAX_WIDTH) ?
        COL_W'(MAX_WIDTH - 1) : COL_W'(FRAME_WIDTH_RESET - 1);

    // Configuration, kept in effective form
    logic [COL_W-1:0] width_last_reg;
    logic [ROW_W-1:0] height_reg;

    // Frame position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Stage waiting for line store read data
    logic                s1_valid_reg;
    logic [MAG_BITS-1:0] s1_mag_reg;
    logic [DIR_W-1:0]    s1_dir_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic                s1_row0_reg;
    ctl_t                s1_ctl_reg;

    // Forwarding for a read that meets a write to the same column
    logic                byp_valid_reg;
    logic [MAG_BITS-1:0] byp_up_reg;
    logic [MAG_BITS-1:0] byp_mid_reg;
    logic [DIR_W-1:0]    byp_dir_reg;

    logic                fire;
    logic                flush_row;
    logic                last_col;
    logic [MAG_BITS-1:0] rd_up, rd_mid, ram_up, ram_mid;
    logic [DIR_W-1:0]    rd_dir, ram_dir;
    logic [MAG_BITS-1:0] col_up, col_mid, col_low, wr_up;
    logic [DIR_W-1:0]    col_dir;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg <= WIDTH_LAST_RESET;
            height_reg     <= ROW_W'(FRAME_HEIGHT_RESET);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    if (cfg_data == '0)
                    begin
                        width_last_reg <= '0;
                    end
                    else if (32'(cfg_data) > 32'(MAX_WIDTH))
                    begin
                        width_last_reg <= COL_W'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        width_last_reg <= COL_W'(cfg_data - CFG_DATA_W'(1));
                    end
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg <= (cfg_data == '0) ? ROW_W'(1) : ROW_W'(cfg_data);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Accept while the queue has room for everything in flight
    assign in_ready  = ((LVL_W + 1)'(q_level) + (LVL_W + 1)'(s1_valid_reg))
                       < (LVL_W + 1)'(QUEUE_DEPTH);
    assign fire      = in_valid && in_ready;
    assign flush_row = (row_reg >= height_reg);
    assign last_col  = (col_reg >= width_last_reg);

    // Counter advance
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = flush_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= fire;
            byp_valid_reg <= fire && s1_valid_reg && (s1_col_reg == col_reg);
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_mag_reg           <= in_mag;
            s1_dir_reg           <= in_dir;
            s1_col_reg           <= col_reg;
            s1_row0_reg          <= (row_reg == '0);
            s1_ctl_reg.first_col <= (col_reg == '0);
            s1_ctl_reg.last_col  <= last_col;
            s1_ctl_reg.emit      <= (row_reg != '0);
            s1_ctl_reg.flush_row <= flush_row;
        end
        byp_up_reg  <= wr_up;
        byp_mid_reg <= s1_mag_reg;
        byp_dir_reg <= s1_dir_reg;
    end

    // Line stores
    enms_ram #(
        .WIDTH (MAG_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (wr_up),
        .re    (fire),
        .raddr (col_reg),
        .rdata (ram_up)
    );

    enms_ram #(
        .WIDTH (MAG_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_middle_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_mag_reg),
        .re    (fire),
        .raddr (col_reg),
        .rdata (ram_mid)
    );

    enms_ram #(
        .WIDTH (DIR_W),
        .DEPTH (MAX_WIDTH)
    ) u_dir_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_dir_reg),
        .re    (fire),
        .raddr (col_reg),
        .rdata (ram_dir)
    );

    // Column assembly; top row clamps upward, flush row clamps downward
    always_comb
    begin
        rd_up  = byp_valid_reg ? byp_up_reg  : ram_up;
        rd_mid = byp_valid_reg ? byp_mid_reg : ram_mid;
        rd_dir = byp_valid_reg ? byp_dir_reg : ram_dir;
        if (s1_row0_reg)
        begin
            col_up  = s1_mag_reg;
            col_mid = s1_mag_reg;
            col_low = s1_mag_reg;
            col_dir = s1_dir_reg;
            wr_up   = s1_mag_reg;
        end
        else
        begin
            col_up  = rd_up;
            col_mid = rd_mid;
            col_low = s1_ctl_reg.flush_row ? rd_mid : s1_mag_reg;
            col_dir = rd_dir;
            wr_up   = rd_mid;
        end
    end

    assign q_push = s1_valid_reg;
    assign q_data = {s1_ctl_reg, col_dir, col_low, col_mid, col_up};

endmodule

[rtl/enms_back.sv]
`timescale 1ns / 1ps
// Back end: 3x3 window, suppression compares and two-slot result buffer.
module enms_back #(
    parameter int MAG_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // column queue
    input  logic                                   q_empty,
    input  logic [3*MAG_BITS+enms_pkg::DIR_W+$bits(enms_pkg::ctl_t)-1:0] q_data,
    output logic                                   q_pop,
    // results
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [MAG_BITS-1:0]                    out_mag,
    output logic                                   out_last,
    output logic                                   out_frame
);

    import enms_pkg::*;

    // Window: [row: upper, middle, lower][col: oldest..newest]
    logic [MAG_BITS-1:0] win_reg [3][3];
    logic [MAG_BITS-1:0] win_next [3][3];
    logic [DIR_W-1:0]    dwin_reg [3];
    logic [DIR_W-1:0]    dwin_next [3];

    // Result slots, slot 0 drives the output
    logic [MAG_BITS-1:0] slot_mag_reg [2];
    logic [MAG_BITS-1:0] slot_mag_next [2];
    logic                slot_last_reg [2];
    logic                slot_last_next [2];
    logic                slot_frame_reg [2];
    logic                slot_frame_next [2];
    logic [1:0]          cnt_reg, cnt_next;

    logic [MAG_BITS-1:0] h_up, h_mid, h_low;
    logic [DIR_W-1:0]    h_dir;
    ctl_t                h_ctl;
    logic [MAG_BITS-1:0] res_a, res_b;
    logic                emit_a, emit_b;
    logic [1:0]          n;
    logic [1:0]          nres;

    // Local maximum test along the coded direction
    function automatic logic [MAG_BITS-1:0] nms(
        input logic [DIR_W-1:0]    d,
        input logic [MAG_BITS-1:0] ctr,
        input logic [MAG_BITS-1:0] l,
        input logic [MAG_BITS-1:0] r,
        input logic [MAG_BITS-1:0] u,
        input logic [MAG_BITS-1:0] b,
        input logic [MAG_BITS-1:0] ur,
        input logic [MAG_BITS-1:0] bl,
        input logic [MAG_BITS-1:0] ul,
        input logic [MAG_BITS-1:0] br
    );
        logic [MAG_BITS-1:0] a;
        logic [MAG_BITS-1:0] c;
        logic [MAG_BITS-1:0] m;
        case (dir_t'(d))
            DIR_HORIZ:
            begin
                a = l;
                c = r;
            end
            DIR_VERT:
            begin
                a = u;
                c = b;
            end
            DIR_DIAG_UR:
            begin
                a = ur;
                c = bl;
            end
            DIR_DIAG_UL:
            begin
                a = ul;
                c = br;
            end
            default:
            begin
                a = '0;
                c = '0;
            end
        endcase
        m = (a > c) ? a : c;
        return (ctr > m) ? ctr : '0;
    endfunction

    assign {h_ctl, h_dir, h_low, h_mid, h_up} = q_data;

    // Window after taking the head column; first column refills all three
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (h_ctl.first_col)
            begin
                win_next[0][k] = h_up;
                win_next[1][k] = h_mid;
                win_next[2][k] = h_low;
                dwin_next[k]   = h_dir;
            end
            else if (k < 2)
            begin
                win_next[0][k] = win_reg[0][k+1];
                win_next[1][k] = win_reg[1][k+1];
                win_next[2][k] = win_reg[2][k+1];
                dwin_next[k]   = dwin_reg[k+1];
            end
            else
            begin
                win_next[0][k] = h_up;
                win_next[1][k] = h_mid;
                win_next[2][k] = h_low;
                dwin_next[k]   = h_dir;
            end
        end
    end

    // Middle column result and right-edge result
    assign res_a = nms(dwin_next[1], win_next[1][1], win_next[1][0], win_next[1][2],
                       win_next[0][1], win_next[2][1], win_next[0][2], win_next[2][0],
                       win_next[0][0], win_next[2][2]);
    assign res_b = nms(dwin_next[2], win_next[1][2], win_next[1][1], win_next[1][2],
                       win_next[0][2], win_next[2][2], win_next[0][2], win_next[2][1],
                       win_next[0][1], win_next[2][2]);

    assign emit_a = h_ctl.emit && !h_ctl.first_col;
    assign emit_b = h_ctl.emit && h_ctl.last_col;
    assign nres   = 2'(emit_a) + 2'(emit_b);

    // Slot buffer: retire head on transfer, then append this column's results
    always_comb
    begin
        slot_mag_next   = slot_mag_reg;
        slot_last_next  = slot_last_reg;
        slot_frame_next = slot_frame_reg;
        n = cnt_reg;
        if ((cnt_reg != 2'd0) && out_ready)
        begin
            slot_mag_next[0]   = slot_mag_reg[1];
            slot_last_next[0]  = slot_last_reg[1];
            slot_frame_next[0] = slot_frame_reg[1];
            n = n - 2'd1;
        end
        q_pop = !q_empty && (({1'b0, n} + {1'b0, nres}) <= 3'd2);
        if (q_pop && emit_a)
        begin
            slot_mag_next[n[0]]   = res_a;
            slot_last_next[n[0]]  = !h_ctl.last_col;
            slot_frame_next[n[0]] = 1'b0;
            n = n + 2'd1;
        end
        if (q_pop && emit_b)
        begin
            slot_mag_next[n[0]]   = res_b;
            slot_last_next[n[0]]  = 1'b1;
            slot_frame_next[n[0]] = h_ctl.flush_row;
            n = n + 2'd1;
        end
        cnt_next = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            for (int k = 0; k < 3; k++)
            begin
                win_reg[0][k] <= '0;
                win_reg[1][k] <= '0;
                win_reg[2][k] <= '0;
                dwin_reg[k]   <= '0;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (q_pop)
            begin
                win_reg  <= win_next;
                dwin_reg <= dwin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_mag_reg   <= slot_mag_next;
        slot_last_reg  <= slot_last_next;
        slot_frame_reg <= slot_frame_next;
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign out_mag   = slot_mag_reg[0];
    assign out_last  = slot_last_reg[0];
    assign out_frame = slot_frame_reg[0];

endmodule

[rtl/edge_non_maximum_suppression.sv]
`timescale 1ns / 1ps
// Top level of the edge non-maximum suppression block.
//
// Pixels arrive in raster order on the s_axis channel: one gradient magnitude
// with its direction code per transfer, frame_height rows of frame_width
// pixels, then one flush row of frame_width transfers (contents ignored).
// Each pixel keeps its magnitude on m_axis if it is strictly greater than
// both neighbors along its direction, else 0; frame borders clamp.
// Results trail the input by one row: the pixel at row r+1, column c yields
// the result for row r, column c-1, and the last pixel of a row also yields
// the result for the last column (two transfers). tlast marks the last
// result of one input transfer, tuser marks the bottom-right pixel.
// Throughput is one pixel per clock while the receiver keeps up; a row end
// gives two results. Results of an accepted pixel pass the line store read
// stage, the column queue and the window compares into the result buffer,
// which raises m_axis_tvalid. cfg writes frame_width (index 0) and
// frame_height (index 1); the user must write them only between frames, as
// the block does not enforce it. Reset clears the counters and the window;
// line stores need no clearing. A stalled receiver fills the 2-slot result
// buffer and the 4-column queue, then s_axis_tready drops; nothing is lost.
module edge_non_maximum_suppression #(
    parameter int MAX_WIDTH = enms_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAG_BITS  = enms_pkg::DEFAULT_MAG_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [enms_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [enms_pkg::CFG_DATA_W-1:0]        cfg_data,
    // pixel input
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((MAG_BITS+7)/8)*8-1:0]          s_axis_tdata,  // magnitude
    input  logic [enms_pkg::TUSER_IN_W-1:0]        s_axis_tuser,  // direction[2:0], flush
    // result output
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((MAG_BITS+7)/8)*8-1:0]          m_axis_tdata,  // suppressed_magnitude
    output logic                                   m_axis_tlast,  // last_of_run
    output logic [0:0]                             m_axis_tuser   // last_of_frame
);

    import enms_pkg::*;

    localparam int TDATA_W = ((MAG_BITS + 7) / 8) * 8;
    localparam int LVL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QW      = 3 * MAG_BITS + DIR_W + $bits(ctl_t);

    logic             q_push;
    logic [QW-1:0]    q_push_data;
    logic             q_pop;
    logic [QW-1:0]    q_head;
    logic             q_empty;
    logic [LVL_W-1:0] q_level;
    logic [MAG_BITS-1:0] res_mag;
    logic             res_frame;

    enms_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAG_BITS    (MAG_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mag    (s_axis_tdata[MAG_BITS-1:0]),
        .in_dir    (s_axis_tuser[DIR_W-1:0]),
        .q_level   (q_level),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    enms_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty),
        .level     (q_level)
    );

    enms_back #(
        .MAG_BITS (MAG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_mag   (res_mag),
        .out_last  (m_axis_tlast),
        .out_frame (res_frame)
    );

    assign m_axis_tdata    = TDATA_W'(res_mag);
    assign m_axis_tuser[0] = res_frame;

`ifndef SYNTHESIS
    // The input credit check keeps the column queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_level < LVL_W'(QUEUE_DEPTH)))
    else $error("column queue push while full");

    // The bottom-right result is always the last one of its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("frame end without run end");

    // Input back-pressure only comes from a filled queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (q_level != '0))
    else $error("input stalled with empty queue");
`endif

endmodule
